/* hdl/bmhq_pkg.sv */
`default_nettype none

package bmhq_pkg;

	localparam int TAG_W        = 10;
	localparam int KEY_W        = 32;
	localparam int CMD_W        = 3;
	localparam int STAT_W       = 2;
	localparam int OCC_W        = 11;
	localparam int TAG_COUNT    = 1 << TAG_W;
	localparam int CAPACITY_DEF = 1024;
	localparam int IN_W         = 48;
	localparam int OUT_W        = 56;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND   = 3'd0,
		CMD_BUILD    = 3'd1,
		CMD_INSERT   = 3'd2,
		CMD_EXTRACT  = 3'd3,
		CMD_DECREASE = 3'd4,
		CMD_PEEK     = 3'd5
	} cmd_e_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_DECR  = 2'd2,
		ST_FULL      = 2'd3
	} status_e_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] key;
	} heap_ent_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD_IN,
		OP_APPEND,
		OP_INS_START,
		OP_UP_RD,
		OP_UP_STEP,
		OP_PLACE,
		OP_DN_RD,
		OP_DN_STEP,
		OP_EXT,
		OP_PEEK,
		OP_BLD_INIT,
		OP_BLD_RD,
		OP_BLD_LD,
		OP_DK_CHK
	} dp_op_t;

	typedef struct packed {
		dp_op_t    op;
		logic      res_valid;
		status_e_t res_status;
	} ctl_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic up_go;
		logic up_swap;
		logic dn_child;
		logic dn_swap;
		logic dk_pos_bad;
		logic dk_bad;
		logic bld_more;
		logic moved;
		logic out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

/* hdl/binary_min_heap_queue.sv */
// channel  | dir | tdata fields (low bit up)                        | width
// s_axis   | in  | command, item_tag, item_key                      | 48
// m_axis   | out | out_tag, out_key, status, occupancy              | 56
//
// One command at a time; a finished result waits in the output register while the next
// beat is taken. A command holds in its last cycle until that register is free.
// Append, peek, unknown commands and refusals for an empty or full heap go straight to the result;
// insert and decrease-key (unless refused) sift up, extract sifts down unless it empties
// the heap, and build sifts down each node from the last parent to the root.
// Each level costs a heap read then a compare; reset clears count, valid and control only.
`default_nettype none

module binary_min_heap_queue #(
	parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire  [bmhq_pkg::IN_W-1:0]    s_axis_tdata,  // command, item_tag, item_key
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [bmhq_pkg::OUT_W-1:0]   m_axis_tdata   // out_tag, out_key, status, occupancy
);
	import bmhq_pkg::*;

	ctl_cmd_t          cmd;
	dp_stat_t          stat;
	logic              accept;
	logic [TAG_W-1:0]  out_tag;
	logic [KEY_W-1:0]  out_key;
	logic [STAT_W-1:0] out_status;
	logic [OCC_W-1:0]  out_occ;

	assign accept = s_axis_tvalid && s_axis_tready;

	bmhq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (s_axis_tdata[2:0]),
		.stat     (stat),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	bmhq_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_tag     (s_axis_tdata[12:3]),
		.in_key     (s_axis_tdata[44:13]),
		.out_ready  (m_axis_tready),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_tag    (out_tag),
		.out_key    (out_key),
		.out_status (out_status),
		.out_occ    (out_occ)
	);

	assign m_axis_tdata = {1'b0, out_occ, out_status, out_key, out_tag};

`ifndef NO_ASSERTIONS
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while waiting");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("second beat taken before the first finished");

	a_result_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_valid |=> m_axis_tvalid)
		else $error("result lost");
`endif

endmodule

`default_nettype wire

/* hdl/bmhq_dp.sv */
`default_nettype none

module bmhq_dp #(
	parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  bmhq_pkg::ctl_cmd_t      cmd,
	input  wire  [bmhq_pkg::TAG_W-1:0]    in_tag,
	input  wire  [bmhq_pkg::KEY_W-1:0]    in_key,
	input  wire                           out_ready,
	output bmhq_pkg::dp_stat_t            stat,
	output logic                          out_valid,
	output logic [bmhq_pkg::TAG_W-1:0]    out_tag,
	output logic [bmhq_pkg::KEY_W-1:0]    out_key,
	output logic [bmhq_pkg::STAT_W-1:0]   out_status,
	output logic [bmhq_pkg::OCC_W-1:0]    out_occ
);
	import bmhq_pkg::*;

	localparam int PW  = $clog2(CAPACITY + 1);
	localparam int PW1 = PW + 1;
	localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	heap_ent_t         heap_mem [CAPACITY];
	logic [PW-1:0]     pos_mem  [TAG_COUNT];

	heap_ent_t         rd_a_q, rd_b_q, cur_q;
	logic [PW-1:0]     posrd_q;
	logic [PW-1:0]     count_q, pos_q, idx_q;
	logic              moved_q, out_valid_q;
	logic [TAG_W-1:0]  res_tag_q;
	logic [KEY_W-1:0]  res_key_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [STAT_W-1:0] out_status_q;
	logic [OCC_W-1:0]  out_occ_q;

	logic [AW-1:0]     ra, rb, hw_addr;
	logic              hw_en, pw_en;
	heap_ent_t         hw_data;
	logic [TAG_W-1:0]  pw_addr;
	logic [PW-1:0]     pw_data;

	logic [PW1-1:0]    left, right;
	logic              right_ok, pick_right;
	heap_ent_t         best;
	logic [PW-1:0]     best_idx;

	assign left       = {pos_q, 1'b0};
	assign right      = {pos_q, 1'b1};
	assign right_ok   = right <= {1'b0, count_q};
	assign pick_right = right_ok && (rd_b_q.key < rd_a_q.key);
	assign best       = pick_right ? rd_b_q : rd_a_q;
	assign best_idx   = pick_right ? right[PW-1:0] : left[PW-1:0];

	always_comb begin
		ra      = '0;
		rb      = AW'(count_q - PW'(1));
		hw_en   = 1'b0;
		hw_addr = AW'(pos_q - PW'(1));
		hw_data = cur_q;
		pw_en   = 1'b0;
		pw_addr = cur_q.tag;
		pw_data = pos_q;
		case (cmd.op)
			OP_UP_RD:  ra = AW'((pos_q >> 1) - PW'(1));
			OP_DN_RD: begin
				ra = AW'(left - PW1'(1));
				rb = AW'(left);
			end
			OP_BLD_RD: ra = AW'(idx_q - PW'(1));
			OP_DK_CHK: ra = AW'(posrd_q - PW'(1));
			OP_APPEND: begin
				hw_en   = 1'b1;
				hw_addr = AW'(count_q);
				pw_en   = 1'b1;
				pw_data = count_q + PW'(1);
			end
			OP_UP_STEP: begin
				hw_en   = 1'b1;
				hw_data = rd_a_q;
				pw_en   = 1'b1;
				pw_addr = rd_a_q.tag;
			end
			OP_PLACE: begin
				hw_en = 1'b1;
				pw_en = 1'b1;
			end
			OP_DN_STEP: begin
				hw_en   = 1'b1;
				hw_data = best;
				pw_en   = 1'b1;
				pw_addr = best.tag;
			end
			OP_EXT: begin
				pw_en   = 1'b1;
				pw_addr = rd_a_q.tag;
				pw_data = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hw_en) begin
			heap_mem[hw_addr] <= hw_data;
		end
		rd_a_q <= heap_mem[ra];
		rd_b_q <= heap_mem[rb];
	end

	always_ff @(posedge clk) begin
		if (pw_en) begin
			pos_mem[pw_addr] <= pw_data;
		end
		posrd_q <= pos_mem[in_tag];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD_IN: begin
				cur_q     <= '{tag: in_tag, key: in_key};
				res_tag_q <= '0;
				res_key_q <= '0;
			end
			OP_INS_START: pos_q <= count_q + PW'(1);
			OP_UP_STEP:   pos_q <= pos_q >> 1;
			OP_DN_STEP: begin
				pos_q   <= best_idx;
				moved_q <= 1'b1;
			end
			OP_EXT: begin
				res_tag_q <= rd_a_q.tag;
				res_key_q <= rd_a_q.key;
				cur_q     <= rd_b_q;
				pos_q     <= PW'(1);
				moved_q   <= 1'b1;
			end
			OP_PEEK: begin
				res_tag_q <= rd_a_q.tag;
				res_key_q <= rd_a_q.key;
			end
			OP_BLD_INIT: idx_q <= count_q >> 1;
			OP_BLD_RD: begin
				pos_q   <= idx_q;
				moved_q <= 1'b0;
			end
			OP_BLD_LD: begin
				cur_q <= rd_a_q;
				idx_q <= idx_q - PW'(1);
			end
			OP_DK_CHK: pos_q <= posrd_q;
			default: ;
		endcase
		if (cmd.res_valid) begin
			out_tag_q    <= res_tag_q;
			out_key_q    <= res_key_q;
			out_status_q <= cmd.res_status;
			out_occ_q    <= OCC_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_APPEND, OP_INS_START: count_q <= count_q + PW'(1);
				OP_EXT:                  count_q <= count_q - PW'(1);
				default: ;
			endcase
			if (cmd.res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.empty      = count_q == '0;
		stat.full       = count_q == PW'(CAPACITY);
		stat.up_go      = pos_q != PW'(1);
		stat.up_swap    = rd_a_q.key > cur_q.key;
		stat.dn_child   = left <= {1'b0, count_q};
		stat.dn_swap    = cur_q.key > best.key;
		stat.dk_pos_bad = (posrd_q == '0) || (posrd_q > count_q);
		stat.dk_bad     = (rd_a_q.tag != cur_q.tag) || (rd_a_q.key < cur_q.key);
		stat.bld_more   = idx_q != '0;
		stat.moved      = moved_q;
		stat.out_busy   = out_valid_q;
	end

	assign out_valid  = out_valid_q;
	assign out_tag    = out_tag_q;
	assign out_key    = out_key_q;
	assign out_status = out_status_q;
	assign out_occ    = out_occ_q;

endmodule

`default_nettype wire

/* hdl/bmhq_ctrl.sv */
`default_nettype none

module bmhq_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          accept,
	input  wire  [bmhq_pkg::CMD_W-1:0]   command,
	input  wire  bmhq_pkg::dp_stat_t     stat,
	output logic                         in_ready,
	output bmhq_pkg::ctl_cmd_t           cmd
);
	import bmhq_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_APP, S_INS, S_UP_RD, S_UP_CMP, S_PLACE, S_DN_RD, S_DN_CMP,
		S_DN_END, S_BINIT, S_BRD, S_BLD, S_EXT, S_EXT2, S_PEEK, S_DK1, S_DK2, S_DONE
	} state_t;

	state_t    state_q, state_d;
	status_e_t status_q, status_d;
	logic      build_q, build_d;

	always_comb begin
		cmd      = '{op: OP_NONE, res_valid: 1'b0, res_status: status_q};
		state_d  = state_q;
		status_d = status_q;
		build_d  = build_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.op   = OP_LOAD_IN;
					status_d = ST_OK;
					build_d  = 1'b0;
					case (command)
						CMD_APPEND:   state_d = S_APP;
						CMD_BUILD:    state_d = S_BINIT;
						CMD_INSERT:   state_d = S_INS;
						CMD_EXTRACT:  state_d = S_EXT;
						CMD_DECREASE: state_d = S_DK1;
						CMD_PEEK:     state_d = S_PEEK;
						default:      state_d = S_DONE;
					endcase
				end
			end
			S_APP: begin
				if (stat.full) begin
					status_d = ST_FULL;
				end else begin
					cmd.op = OP_APPEND;
				end
				state_d = S_DONE;
			end
			S_INS: begin
				if (stat.full) begin
					status_d = ST_FULL;
					state_d  = S_DONE;
				end else begin
					cmd.op  = OP_INS_START;
					state_d = S_UP_RD;
				end
			end
			S_UP_RD: begin
				if (stat.up_go) begin
					cmd.op  = OP_UP_RD;
					state_d = S_UP_CMP;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_UP_CMP: begin
				if (stat.up_swap) begin
					cmd.op  = OP_UP_STEP;
					state_d = S_UP_RD;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.op  = OP_PLACE;
				state_d = S_DONE;
			end
			S_DN_RD: begin
				if (stat.dn_child) begin
					cmd.op  = OP_DN_RD;
					state_d = S_DN_CMP;
				end else begin
					state_d = S_DN_END;
				end
			end
			S_DN_CMP: begin
				if (stat.dn_swap) begin
					cmd.op  = OP_DN_STEP;
					state_d = S_DN_RD;
				end else begin
					state_d = S_DN_END;
				end
			end
			S_DN_END: begin
				if (stat.moved) begin
					cmd.op = OP_PLACE;
				end
				state_d = build_q ? S_BRD : S_DONE;
			end
			S_BINIT: begin
				cmd.op  = OP_BLD_INIT;
				build_d = 1'b1;
				state_d = S_BRD;
			end
			S_BRD: begin
				if (stat.bld_more) begin
					cmd.op  = OP_BLD_RD;
					state_d = S_BLD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_BLD: begin
				cmd.op  = OP_BLD_LD;
				state_d = S_DN_RD;
			end
			S_EXT: begin
				if (stat.empty) begin
					status_d = ST_EMPTY;
					state_d  = S_DONE;
				end else begin
					cmd.op  = OP_EXT;
					state_d = S_EXT2;
				end
			end
			S_EXT2: state_d = stat.empty ? S_DONE : S_DN_RD;
			S_PEEK: begin
				if (stat.empty) begin
					status_d = ST_EMPTY;
				end else begin
					cmd.op = OP_PEEK;
				end
				state_d = S_DONE;
			end
			S_DK1: begin
				if (stat.empty) begin
					status_d = ST_EMPTY;
					state_d  = S_DONE;
				end else if (stat.dk_pos_bad) begin
					status_d = ST_NOT_DECR;
					state_d  = S_DONE;
				end else begin
					cmd.op  = OP_DK_CHK;
					state_d = S_DK2;
				end
			end
			S_DK2: begin
				if (stat.dk_bad) begin
					status_d = ST_NOT_DECR;
					state_d  = S_DONE;
				end else begin
					state_d = S_UP_RD;
				end
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.res_valid = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
			build_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			build_q  <= build_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

endmodule

`default_nettype wire
